FILE: sv/skcr_pkg.sv
// ----------------------------------------------------------------------------
// skcr_pkg
// shared types and constants of the sorted key cell range builder
// ----------------------------------------------------------------------------
package skcr_pkg;

	localparam int unsigned MAX_CELLS_DEF    = 4096;
	localparam int unsigned PARTICLE_CAP_DEF = 262144;
	localparam int unsigned LANES_DEF        = 8;

	localparam int unsigned CELL_W  = 12;
	localparam int unsigned BEGIN_W = 18;
	localparam int unsigned END_W   = 19;
	localparam int unsigned OFS_W   = 16;
	localparam int unsigned COUNT_W = 19;

	// command codes
	localparam logic [1:0] OP_CLEAR = 2'd0;
	localparam logic [1:0] OP_PUSH  = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	typedef struct packed {
		logic [1:0]        opcode;
		logic [CELL_W-1:0] cell_index;
		logic              is_dead;
	} cmd_t;

	typedef struct packed {
		logic [BEGIN_W-1:0] run_begin;
		logic [END_W-1:0]   run_end;
		logic [OFS_W-1:0]   block_offset;
		logic [COUNT_W-1:0] live_total;
	} result_t;

	// one word of the cell table
	typedef struct packed {
		logic [BEGIN_W-1:0] run_begin;
		logic [END_W-1:0]   run_end;
		logic [OFS_W-1:0]   block_offset;
	} entry_t;

	// control from the top level to the run tracker
	typedef struct packed {
		logic push;
		logic clear;
	} run_ctl_t;

	function automatic int unsigned addr_width(input int unsigned depth);
		return (depth > 1) ? $clog2(depth) : 1;
	endfunction

endpackage

FILE: sv/skcr_ram.sv
// ----------------------------------------------------------------------------
// skcr_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module skcr_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16,
	localparam int unsigned AW   = skcr_pkg::addr_width(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: sv/skcr_run_ctrl.sv
// ----------------------------------------------------------------------------
// skcr_run_ctrl
// run tracking: particle counter, current run, block sum and table write word
// ----------------------------------------------------------------------------
module skcr_run_ctrl #(
	parameter int unsigned MAX_CELLS     = skcr_pkg::MAX_CELLS_DEF,
	parameter int unsigned PARTICLE_CAP  = skcr_pkg::PARTICLE_CAP_DEF,
	parameter int unsigned LANES         = skcr_pkg::LANES_DEF,
	localparam int unsigned AW           = skcr_pkg::addr_width(MAX_CELLS)
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  skcr_pkg::run_ctl_t               ctl,
	input  logic [skcr_pkg::CELL_W-1:0]      cell_index,
	input  logic                             is_dead,
	output logic                             wr_en,
	output logic [AW-1:0]                    wr_addr,
	output skcr_pkg::entry_t                 wr_data,
	output logic [skcr_pkg::COUNT_W-1:0]     live_count
);

	localparam int unsigned LW = (LANES > 1) ? $clog2(LANES) : 1;

	logic [skcr_pkg::COUNT_W-1:0] count_q;
	logic [skcr_pkg::CELL_W-1:0]  prev_q;
	logic [skcr_pkg::BEGIN_W-1:0] run_start_q;
	logic [skcr_pkg::OFS_W-1:0]   block_sum_q;
	logic [skcr_pkg::OFS_W-1:0]   run_blocks_q;
	logic [LW-1:0]                lane_q;
	logic                         dead_q;

	logic                         in_range, full, take, live, open_run;
	logic [skcr_pkg::OFS_W-1:0]   sum_next;
	logic [skcr_pkg::BEGIN_W-1:0] begin_next;
	logic [31:0]                  cell_ext;

	function automatic logic [LW-1:0] lane_step(input logic [LW-1:0] x);
		return (x == LW'(LANES - 1)) ? '0 : LW'(x + 1'b1);
	endfunction

	assign cell_ext = 32'(cell_index);
	assign in_range = cell_ext < MAX_CELLS;
	assign full     = 32'(count_q) >= PARTICLE_CAP;
	assign take     = ctl.push && !dead_q && !full && in_range;
	assign live     = take && !is_dead;
	assign open_run = (count_q == '0) || (cell_index != prev_q);

	// closing a run adds its block count to the running sum
	assign sum_next   = (open_run && count_q != '0) ? block_sum_q + run_blocks_q : block_sum_q;
	assign begin_next = open_run ? count_q[skcr_pkg::BEGIN_W-1:0] : run_start_q;

	assign wr_en                = live;
	assign wr_addr              = cell_ext[AW-1:0];
	assign wr_data.run_begin    = begin_next;
	assign wr_data.run_end      = count_q + 1'b1;
	assign wr_data.block_offset = sum_next;
	assign live_count           = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			prev_q       <= '0;
			run_start_q  <= '0;
			block_sum_q  <= '0;
			run_blocks_q <= '0;
			lane_q       <= '0;
			dead_q       <= 1'b0;
		end else if (ctl.clear) begin
			count_q      <= '0;
			prev_q       <= '0;
			run_start_q  <= '0;
			block_sum_q  <= '0;
			run_blocks_q <= '0;
			lane_q       <= '0;
			dead_q       <= 1'b0;
		end else if (take && is_dead) begin
			dead_q <= 1'b1;
		end else if (live) begin
			count_q <= count_q + 1'b1;
			if (open_run) begin
				prev_q       <= cell_index;
				run_start_q  <= begin_next;
				block_sum_q  <= sum_next;
				run_blocks_q <= skcr_pkg::OFS_W'(1);
				lane_q       <= lane_step('0);
			end else begin
				if (lane_q == '0) begin
					run_blocks_q <= run_blocks_q + 1'b1;
				end
				lane_q <= lane_step(lane_q);
			end
		end
	end

endmodule

FILE: sv/sorted_key_cell_range_builder.sv
// ----------------------------------------------------------------------------
// sorted_key_cell_range_builder
// uniform grid cell table built from a stream of sorted particle keys
// ----------------------------------------------------------------------------
// Commands are taken when start is high and busy is low. A new command can
// follow a push straight away. A read's result is registered through rd_s1
// and then into result, where it appears with done high for exactly one
// cycle, and reads may be issued back to back. The result cannot be held
// off, so capture it when done is high. A clear, and likewise the period
// after reset, walks the cell table one entry per cycle through its single
// write port: busy stays high until all MAX_CELLS entries (4096 by default)
// are zeroed and no command is taken in that time. Pushes whose cell is
// outside the table, pushes past PARTICLE_CAP and everything pushed after
// the first dead key are dropped; an empty cell reads as zeros.
// ----------------------------------------------------------------------------
module sorted_key_cell_range_builder #(
	parameter int unsigned MAX_CELLS     = skcr_pkg::MAX_CELLS_DEF,
	parameter int unsigned PARTICLE_CAP  = skcr_pkg::PARTICLE_CAP_DEF,
	parameter int unsigned LANES         = skcr_pkg::LANES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  skcr_pkg::cmd_t    cmd,
	output logic              done,
	output skcr_pkg::result_t result
);

	localparam int unsigned AW = skcr_pkg::addr_width(MAX_CELLS);
	localparam int unsigned EW = $bits(skcr_pkg::entry_t);

	typedef enum logic {
		ST_SWEEP,
		ST_RUN
	} state_t;

	state_t  state_q;
	logic [AW-1:0] sweep_addr_q;

	// command decode
	logic accept, do_clear, do_push, do_read;
	logic [31:0] cell_ext;
	logic [AW-1:0] cell_addr;
	logic cell_in_range;

	// run tracker
	skcr_pkg::run_ctl_t             run_ctl;
	logic                           push_we;
	logic [AW-1:0]                  push_addr;
	skcr_pkg::entry_t               push_data;
	logic [skcr_pkg::COUNT_W-1:0]   live_count;

	// table port
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [EW-1:0]     mem_wdata;
	logic [EW-1:0]     mem_rdata;
	skcr_pkg::entry_t  rd_entry;

	// read pipeline
	logic                          rd_s1;
	logic                          range_s1;
	logic [skcr_pkg::COUNT_W-1:0]  live_s1;

	assign busy   = (state_q == ST_SWEEP);
	assign accept = start && !busy;

	always_comb begin
		do_clear = 1'b0;
		do_push  = 1'b0;
		do_read  = 1'b0;
		case (cmd.opcode)
			skcr_pkg::OP_CLEAR: do_clear = accept;
			skcr_pkg::OP_PUSH:  do_push  = accept;
			skcr_pkg::OP_READ:  do_read  = accept;
			default: ;
		endcase
	end

	assign cell_ext      = 32'(cmd.cell_index);
	assign cell_addr     = cell_ext[AW-1:0];
	assign cell_in_range = cell_ext < MAX_CELLS;

	assign run_ctl.push  = do_push;
	assign run_ctl.clear = do_clear;

	skcr_run_ctrl #(
		.MAX_CELLS     (MAX_CELLS),
		.PARTICLE_CAP  (PARTICLE_CAP),
		.LANES         (LANES)
	) u_run_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (run_ctl),
		.cell_index (cmd.cell_index),
		.is_dead    (cmd.is_dead),
		.wr_en      (push_we),
		.wr_addr    (push_addr),
		.wr_data    (push_data),
		.live_count (live_count)
	);

	// the sweep owns the write port while busy, pushes only arrive otherwise
	assign mem_we    = busy || push_we;
	assign mem_waddr = busy ? sweep_addr_q : push_addr;
	assign mem_wdata = busy ? '0 : EW'(push_data);

	skcr_ram #(
		.WIDTH (EW),
		.DEPTH (MAX_CELLS)
	) u_table (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (cell_addr),
		.rdata (mem_rdata)
	);

	assign rd_entry = skcr_pkg::entry_t'(mem_rdata);

	// sweep sequencer: zeroes the table after reset and on clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_SWEEP;
			sweep_addr_q <= '0;
		end else begin
			case (state_q)
				ST_SWEEP: begin
					if (sweep_addr_q == AW'(MAX_CELLS - 1)) begin
						state_q      <= ST_RUN;
						sweep_addr_q <= '0;
					end else begin
						sweep_addr_q <= sweep_addr_q + 1'b1;
					end
				end
				ST_RUN: begin
					if (do_clear) begin
						state_q      <= ST_SWEEP;
						sweep_addr_q <= '0;
					end
				end
				default: begin
					state_q      <= ST_SWEEP;
					sweep_addr_q <= '0;
				end
			endcase
		end
	end

	// stage 1 waits for the table word, live count is taken with the read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s1 <= 1'b0;
			done  <= 1'b0;
		end else begin
			rd_s1 <= do_read;
			done  <= rd_s1;
		end
	end

	always_ff @(posedge clk) begin
		range_s1 <= cell_in_range;
		live_s1  <= live_count;
		if (rd_s1) begin
			// an empty or out of range cell reads as zeros
			if (range_s1 && rd_entry.run_end != '0) begin
				result.run_begin    <= rd_entry.run_begin;
				result.run_end      <= rd_entry.run_end;
				result.block_offset <= rd_entry.block_offset;
			end else begin
				result.run_begin    <= '0;
				result.run_end      <= '0;
				result.block_offset <= '0;
			end
			result.live_total <= live_s1;
		end
	end

	// a read always yields its item on done, by way of rd_s1
	a_read_done : assert property (@(posedge clk) disable iff (!arst_n)
		do_read |-> ##2 done)
		else $error("read item not delivered");

	// a clear must hold off commands on the next cycle
	a_clear_busy : assert property (@(posedge clk) disable iff (!arst_n)
		do_clear |=> busy)
		else $error("clear did not start the sweep");

	// the sweep and a push never share the write port
	a_port_excl : assert property (@(posedge clk) disable iff (!arst_n)
		!(busy && push_we))
		else $error("table write conflict");

	// an empty entry gives an all zero run
	a_empty_zero : assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.run_end == '0) |->
			(result.run_begin == '0 && result.block_offset == '0))
		else $error("empty cell returned data");

	// the live count never passes the capacity
	a_live_cap : assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (32'(result.live_total) <= PARTICLE_CAP))
		else $error("live count beyond capacity");

endmodule
